// ----- hdl/sat_pkg.sv -----
package sat_pkg;

   localparam int unsigned DEF_MAX_SECTIONS = 16;
   localparam int unsigned WORD_W = 32;

   // configuration register indexes
   localparam logic [2:0] CSR_IMAGE_SIZE    = 3'd0;
   localparam logic [2:0] CSR_FILE_ALIGN    = 3'd1;
   localparam logic [2:0] CSR_SECTION_ALIGN = 3'd2;
   localparam logic [2:0] CSR_HEADER_END    = 3'd3;
   localparam logic [2:0] CSR_REGION_COUNT  = 3'd4;

   // request kinds
   localparam logic REQ_LOAD      = 1'b0;
   localparam logic REQ_TRANSLATE = 1'b1;

   // result outcome codes
   localparam logic [1:0] OC_MAPPED  = 2'd0;
   localparam logic [1:0] OC_PASS    = 2'd1;
   localparam logic [1:0] OC_INVALID = 2'd2;
   localparam logic [1:0] OC_REALIGN = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load_req;    // capture request item
      logic write_entry; // write table entry from captured load
      logic rd_issue;    // read entry at walk index
      logic walk_clear;  // reset walk index to zero
      logic walk_next;   // advance walk index
      logic cmp_step;    // evaluate current entry against offset
      logic div_start;   // start realign division
      logic div_step;    // one division step
      logic fin_mul;     // form realigned result
      logic out_load;    // move result into output register
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_translate;
      logic early_done;  // decided before the walk
      logic walk_done;   // decided during the walk
      logic need_div;    // boundary case found
      logic walk_last;   // no more entries
      logic div_done;
   } sts_type;

endpackage

// ----- hdl/sat_ctrl.sv -----
module sat_ctrl
   import sat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_READ, ST_CMP, ST_DIV, ST_MUL, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      ctl          = '0;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctl.walk_clear = 1'b1;
            if (!sts.is_translate) begin
               ctl.write_entry = 1'b1;
               state_in        = ST_IDLE;
            end else if (sts.early_done) begin
               state_in = ST_OUT;
            end else begin
               // walk index is cleared at this edge, read entry zero next
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ctl.rd_issue = 1'b1;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            ctl.cmp_step = 1'b1;
            if (sts.walk_done) begin
               state_in = ST_OUT;
            end else if (sts.need_div) begin
               ctl.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (sts.walk_last) begin
               state_in = ST_OUT;
            end else begin
               ctl.walk_next = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ctl.fin_mul = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               ctl.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- hdl/sat_dp.sv -----
module sat_dp
   import sat_pkg::*;
#(
   parameter int unsigned MAX_SECTIONS = DEF_MAX_SECTIONS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_tdata_type,
   input  logic [135:0] req_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  ctl_type     ctl,
   output sts_type     sts,
   output logic [39:0] rsp_tdata
);

   localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

   logic [31:0] image_size_ff, file_align_ff, section_align_ff, header_end_ff;
   logic [4:0]  region_count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff    <= '0;
         file_align_ff    <= 32'd512;
         section_align_ff <= 32'd4096;
         header_end_ff    <= '0;
         region_count_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_SIZE:    image_size_ff    <= csr_wdata;
            CSR_FILE_ALIGN:    file_align_ff    <= csr_wdata;
            CSR_SECTION_ALIGN: section_align_ff <= csr_wdata;
            CSR_HEADER_END:    header_end_ff    <= csr_wdata;
            CSR_REGION_COUNT:  region_count_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // captured request item
   logic        rtype_ff;
   logic [3:0]  ridx_ff;
   logic [31:0] rvb_ff, rvs_ff, rraw_ff, off_ff;
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         rtype_ff <= req_tdata_type[0];
         ridx_ff  <= req_tdata[3:0];
         rvb_ff   <= req_tdata[35:4];
         rvs_ff   <= req_tdata[67:36];
         rraw_ff  <= req_tdata[99:68];
         off_ff   <= req_tdata[131:100];
      end
   end

   // effective region count, clamped
   logic [CNT_W-1:0] n_eff;
   always_comb begin
      if (32'(region_count_ff) > 32'(MAX_SECTIONS)) begin
         n_eff = CNT_W'(MAX_SECTIONS);
      end else begin
         n_eff = CNT_W'(region_count_ff);
      end
   end

   // region table memory, one entry of base, size and raw base
   logic [95:0]      mem [MAX_SECTIONS];
   logic [95:0]      cur_ff, nxt_ff;
   logic [CNT_W-1:0] walk_ff;
   logic [CNT_W-1:0] walk_p1;
   assign walk_p1 = walk_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (ctl.write_entry && (32'(ridx_ff) < 32'(MAX_SECTIONS))) begin
         mem[IDX_W'(ridx_ff)] <= {rraw_ff, rvs_ff, rvb_ff};
      end
      if (ctl.rd_issue) begin
         cur_ff <= mem[walk_ff[IDX_W-1:0]];
         nxt_ff <= mem[(walk_p1 < n_eff) ? walk_p1[IDX_W-1:0] : walk_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.walk_clear) begin
         walk_ff <= '0;
      end else if (ctl.walk_next) begin
         walk_ff <= walk_p1;
      end
   end

   // pre-walk decision
   logic        early;
   logic [31:0] early_val;
   logic [1:0]  early_oc;
   always_comb begin
      early     = 1'b1;
      early_val = off_ff;
      early_oc  = OC_PASS;
      if (off_ff > image_size_ff) begin
         early_val = '0;
         early_oc  = OC_INVALID;
      end else if (file_align_ff == section_align_ff || off_ff <= header_end_ff) begin
         early_oc = OC_PASS;
      end else if (n_eff == '0) begin
         early_oc = OC_PASS;
      end else begin
         early = 1'b0;
      end
   end

   // entry compare
   logic [32:0] c_end;
   logic [31:0] c_base, c_raw, n_base, rel;
   logic        has_next, in_gap, in_reg, at_bound, before_first;
   assign c_base       = cur_ff[31:0];
   assign c_raw        = cur_ff[95:64];
   assign c_end        = {1'b0, c_base} + {1'b0, cur_ff[63:32]};
   assign n_base       = nxt_ff[31:0];
   assign has_next     = (walk_p1 < n_eff);
   assign rel          = off_ff - c_base;
   assign before_first = (walk_ff == '0) && (off_ff < c_base);
   assign in_gap       = has_next && ({1'b0, off_ff} > c_end) && (off_ff < n_base);
   assign in_reg       = (off_ff >= c_base) && ({1'b0, off_ff} <= c_end);
   assign at_bound     = has_next && ({1'b0, off_ff} == c_end) && (off_ff == n_base);

   // restoring divider, one quotient bit a step
   logic [31:0] q_ff, rem_ff, dvd_ff, raw_hold_ff;
   logic [5:0]  dcnt_ff;
   logic [32:0] trial;
   assign trial = {rem_ff, dvd_ff[31]} - {1'b0, section_align_ff};
   always_ff @(posedge clock) begin
      if (ctl.div_start) begin
         q_ff        <= '0;
         rem_ff      <= '0;
         dvd_ff      <= rel;
         raw_hold_ff <= c_raw;
         dcnt_ff     <= '0;
      end else if (ctl.div_step && dcnt_ff != 6'd32) begin
         dvd_ff  <= {dvd_ff[30:0], 1'b0};
         dcnt_ff <= dcnt_ff + 6'd1;
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            q_ff   <= {q_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], dvd_ff[31]};
            q_ff   <= {q_ff[30:0], 1'b0};
         end
      end
   end

   // result register before output
   logic [31:0] res_ff;
   logic [1:0]  oc_ff;
   logic [63:0] prod;
   logic [31:0] q_eff;
   assign q_eff = (section_align_ff == '0) ? '0 : q_ff;
   assign prod  = q_eff * file_align_ff;
   always_ff @(posedge clock) begin
      if (ctl.walk_clear) begin
         res_ff <= early_val;
         oc_ff  <= early_oc;
      end else if (ctl.cmp_step) begin
         if (before_first || in_gap) begin
            res_ff <= '0;
            oc_ff  <= OC_INVALID;
         end else if (in_reg && !at_bound) begin
            res_ff <= c_raw + rel;
            oc_ff  <= OC_MAPPED;
         end else begin
            res_ff <= off_ff;
            oc_ff  <= OC_PASS;
         end
      end else if (ctl.fin_mul) begin
         res_ff <= raw_hold_ff + prod[31:0];
         oc_ff  <= OC_REALIGN;
      end
   end

   logic [31:0] out_off_ff;
   logic [1:0]  out_oc_ff;
   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         out_off_ff <= res_ff;
         out_oc_ff  <= oc_ff;
      end
   end
   assign rsp_tdata = {6'd0, out_oc_ff, out_off_ff};

   assign sts.is_translate = (rtype_ff == REQ_TRANSLATE);
   assign sts.early_done   = early;
   assign sts.walk_done    = before_first || in_gap || (in_reg && !at_bound);
   assign sts.need_div     = in_reg && at_bound;
   assign sts.walk_last    = !has_next;
   assign sts.div_done     = (dcnt_ff == 6'd32);

endmodule

// ----- hdl/section_address_translator.sv -----
// Section address translator. A load item (tuser 0) writes one region entry
// and gives no result; after acceptance it is decoded and written, and then
// the input is ready again. A translate item (tuser 1) gives one result item:
// it is accepted, decoded, then each region entry visited is read and then
// compared, and the result is moved to the output register; at most
// region_count entries are visited, with region_count clamped to MAX_SECTIONS.
// The boundary realign case adds a bit-serial division and a multiply step
// before the output. One item is in work at a time; the output
// register holds a result while the next item is taken, and a new result
// waits in place until the held one is taken.
module section_address_translator
   import sat_pkg::*;
#(
   parameter int unsigned MAX_SECTIONS = DEF_MAX_SECTIONS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // region_index, region_vbase, region_vsize,
                                    // region_raw_base, virt_offset
   input  logic         req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // file_offset, outcome
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   ctl_type ctl;
   sts_type sts;

   sat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   sat_dp #(.MAX_SECTIONS(MAX_SECTIONS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_tdata_type ({7'd0, req_tuser}),
      .req_tdata      (req_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .ctl            (ctl),
      .sts            (sts),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

// ----- hdl/sat_checker.sv -----
module sat_checker
   import sat_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // a load item never produces a result right after
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_LOAD && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after load item");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // invalid outcome carries zero offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] == OC_INVALID |-> rsp_tdata[31:0] == '0)
      else $error("invalid outcome with nonzero offset");

endmodule

bind section_address_translator sat_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
